// ===== design/qpcr_pkg.sv =====
`default_nettype none

package qpcr_pkg;

  // Item layout widths
  localparam int WORD_BITS  = 32;
  localparam int EXT_BITS   = 64;
  localparam int SCALE_BITS = 26;
  // Quotient bits kept by the divider: enough to see any 32-bit saturation
  localparam int QUO_BITS   = 33;

  localparam logic [SCALE_BITS-1:0] SCALE_PER_SEC = SCALE_BITS'(1000000);
  localparam logic [SCALE_BITS-1:0] SCALE_PER_MIN = SCALE_BITS'(60000000);

  localparam logic [QUO_BITS-1:0] QUO_POS_MAX = QUO_BITS'(64'h0000_0000_7FFF_FFFF);
  localparam logic [QUO_BITS-1:0] QUO_NEG_MAX = QUO_BITS'(64'h0000_0000_8000_0000);
  localparam logic [WORD_BITS-1:0] RATE_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [WORD_BITS-1:0] RATE_NEG_SAT = 32'h8000_0000;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUAD   = 8'd1;

  typedef enum logic [1:0] {
    OP_EDGE     = 2'd0,
    OP_PRESET   = 2'd1,
    OP_RATE_SEC = 2'd2,
    OP_RATE_MIN = 2'd3
  } qpcr_op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_DISABLED  = 2'd1,
    STAT_ZERO_TIME = 2'd2,
    STAT_SATURATED = 2'd3
  } qpcr_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CHECK,
    ST_DIV,
    ST_FIN
  } qpcr_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic check;
    logic div;
    logic fin_load;
  } qpcr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rate_go;
    logic chunk_last;
    logic sat_early;
    logic div_last;
  } qpcr_sts_t;

endpackage

`default_nettype wire

// ===== design/qpcr_ctrl.sv =====
`default_nettype none

module qpcr_ctrl import qpcr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_tvalid_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  wire logic      m_tready_i,
  input  wire qpcr_sts_t sts_i,
  output qpcr_cmd_t      cmd_o
);

  qpcr_state_e state_q, state_d;
  logic        m_tvalid_q, m_tvalid_d;
  logic        out_free;

  assign out_free   = !m_tvalid_q || m_tready_i;
  assign m_tvalid_o = m_tvalid_q;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    m_tvalid_d = m_tvalid_q && !m_tready_i;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.rate_go ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.chunk_last ? ST_CHECK : ST_MUL;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.sat_early ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.fin_load = 1'b1;
          m_tvalid_d     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_fin_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=> m_tvalid_q)
    else $error("finished result not presented");

  a_simple_item_skips_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && s_tvalid_i && !sts_i.rate_go) |=> state_q == ST_FIN)
    else $error("non-dividing item entered the divider");

  a_div_ends_in_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && sts_i.div_last) |=> state_q == ST_FIN)
    else $error("divider overran its last step");

endmodule

`default_nettype wire

// ===== design/qpcr_dp.sv =====
`default_nettype none

module qpcr_dp import qpcr_pkg::*; #(
  parameter int COUNT_BITS = 32,
  parameter int TIME_BITS  = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic                      cfg_data_i,
  // input item fields
  input  wire logic [1:0]                cmd_i,
  input  wire logic                      level_a_i,
  input  wire logic                      level_b_i,
  input  wire logic [WORD_BITS-1:0]      preset_value_i,
  input  wire logic [WORD_BITS-1:0]      now_us_i,
  // result fields
  output logic [WORD_BITS-1:0]           count_value_o,
  output logic [WORD_BITS-1:0]           rate_value_o,
  output logic [1:0]                     status_o,
  // control
  input  wire qpcr_cmd_t                 cmd_in_i,
  output qpcr_sts_t                      sts_o
);

  localparam int NCH = (COUNT_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int MW  = NCH * WORD_BITS;
  localparam int AW  = MW + SCALE_BITS;
  localparam int PPW = WORD_BITS + SCALE_BITS;
  localparam int HW  = AW - QUO_BITS;
  localparam int CW  = (HW > TIME_BITS) ? HW : TIME_BITS;
  localparam int CHW = $clog2(NCH + 1);
  localparam int DCW = $clog2(QUO_BITS + 1);

  // Configuration and measurement state
  logic                  enable_q;
  logic                  quad_q;
  logic [COUNT_BITS-1:0] pulse_count_q;
  logic [TIME_BITS-1:0]  last_time_q;
  logic [COUNT_BITS-1:0] last_count_q;

  // Per-item working registers
  logic                  rate_cmd_q;
  logic                  zero_q;
  logic                  neg_q;
  logic                  per_min_q;
  logic [TIME_BITS-1:0]  elapsed_q;
  logic [MW-1:0]         mshift_q;
  logic [CHW-1:0]        ch_q;
  logic [PPW-1:0]        pp_q;
  logic [AW-1:0]         acc_q;
  logic                  sat_q;
  logic [TIME_BITS-1:0]  rem_q;
  logic [QUO_BITS-1:0]   low_q;
  logic [QUO_BITS-1:0]   quo_q;
  logic [DCW-1:0]        dcnt_q;

  // Output payload registers
  logic [WORD_BITS-1:0]  count_q;
  logic [WORD_BITS-1:0]  rate_q;
  logic [1:0]            status_q;

  qpcr_op_e              op;
  logic [EXT_BITS-1:0]   now_ext;
  logic [EXT_BITS-1:0]   preset_ext;
  logic [EXT_BITS-1:0]   count_ext;
  logic [TIME_BITS-1:0]  now_t;
  logic [TIME_BITS-1:0]  elapsed_w;
  logic [COUNT_BITS-1:0] diff_w;
  logic                  neg_w;
  logic [COUNT_BITS-1:0] mag_w;
  logic                  is_rate;
  logic                  up;
  logic [SCALE_BITS-1:0] scale_w;
  logic [PPW-1:0]        pp_w;
  logic [CW-1:0]         hi_w;
  logic                  hi_ge;
  logic [TIME_BITS:0]    trial;
  logic                  trial_ge;
  logic [TIME_BITS:0]    trial_sub;
  logic                  pos_sat;
  logic                  neg_sat;
  logic [WORD_BITS-1:0]  rate_w;
  logic [1:0]            status_w;

  assign op         = qpcr_op_e'(cmd_i);
  assign now_ext    = EXT_BITS'(now_us_i);
  assign now_t      = now_ext[TIME_BITS-1:0];
  assign preset_ext = {{(EXT_BITS - WORD_BITS){preset_value_i[WORD_BITS-1]}}, preset_value_i};
  assign elapsed_w  = now_t - last_time_q;
  assign diff_w     = pulse_count_q - last_count_q;
  assign neg_w      = diff_w[COUNT_BITS-1];
  assign mag_w      = neg_w ? (COUNT_BITS'(0) - diff_w) : diff_w;
  assign is_rate    = (op == OP_RATE_SEC) || (op == OP_RATE_MIN);
  assign up         = quad_q ? (level_a_i ^ level_b_i) : 1'b1;

  // Scaled product: one 32-bit chunk of the magnitude per multiply
  assign scale_w = per_min_q ? SCALE_PER_MIN : SCALE_PER_SEC;
  assign pp_w    = PPW'(mshift_q[MW-1 -: WORD_BITS]) * PPW'(scale_w);

  // Overflow precheck: quotient at least 2^QUO_BITS
  assign hi_w  = CW'(acc_q[AW-1:QUO_BITS]);
  assign hi_ge = hi_w >= CW'(elapsed_q);

  // Restoring divide step
  assign trial     = {rem_q, low_q[QUO_BITS-1]};
  assign trial_ge  = trial >= {1'b0, elapsed_q};
  assign trial_sub = trial - {1'b0, elapsed_q};

  assign sts_o.rate_go    = enable_q && is_rate && (elapsed_w != '0);
  assign sts_o.chunk_last = (ch_q == '0);
  assign sts_o.sat_early  = hi_ge;
  assign sts_o.div_last   = (dcnt_q == DCW'(1));

  // Saturate and sign the quotient
  assign pos_sat = sat_q || (quo_q > QUO_POS_MAX);
  assign neg_sat = sat_q || (quo_q > QUO_NEG_MAX);
  assign count_ext = EXT_BITS'(pulse_count_q);

  always_comb begin
    rate_w   = '0;
    status_w = STAT_OK;
    if (!enable_q) begin
      status_w = STAT_DISABLED;
    end else if (rate_cmd_q) begin
      if (zero_q) begin
        status_w = STAT_ZERO_TIME;
      end else if (neg_q) begin
        rate_w = neg_sat ? RATE_NEG_SAT : (WORD_BITS'(0) - quo_q[WORD_BITS-1:0]);
        if (neg_sat) begin
          status_w = STAT_SATURATED;
        end
      end else begin
        rate_w = pos_sat ? RATE_POS_SAT : quo_q[WORD_BITS-1:0];
        if (pos_sat) begin
          status_w = STAT_SATURATED;
        end
      end
    end
  end

  // Configuration and count state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      quad_q        <= 1'b0;
      pulse_count_q <= '0;
      last_time_q   <= '0;
      last_count_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_ENABLE) begin
          enable_q <= cfg_data_i;
        end else if (cfg_index_i == REG_QUAD) begin
          quad_q <= cfg_data_i;
        end
      end
      if (cmd_in_i.load) begin
        if (op == OP_PRESET) begin
          pulse_count_q <= preset_ext[COUNT_BITS-1:0];
        end else if (enable_q && op == OP_EDGE) begin
          pulse_count_q <= up ? (pulse_count_q + COUNT_BITS'(1))
                              : (pulse_count_q - COUNT_BITS'(1));
        end else if (enable_q) begin
          last_time_q  <= now_t;
          last_count_q <= pulse_count_q;
        end
      end
    end
  end

  // Working registers for the rate computation
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.load) begin
      rate_cmd_q <= enable_q && is_rate;
      zero_q     <= (elapsed_w == '0);
      neg_q      <= neg_w;
      per_min_q  <= (op == OP_RATE_MIN);
      elapsed_q  <= elapsed_w;
      mshift_q   <= MW'(mag_w);
      ch_q       <= CHW'(NCH);
      acc_q      <= '0;
      sat_q      <= 1'b0;
    end
    if (cmd_in_i.mul) begin
      pp_q     <= pp_w;
      mshift_q <= mshift_q << WORD_BITS;
      ch_q     <= ch_q - CHW'(1);
    end
    if (cmd_in_i.acc) begin
      acc_q <= (acc_q << WORD_BITS) + AW'(pp_q);
    end
    if (cmd_in_i.check) begin
      sat_q  <= hi_ge;
      rem_q  <= hi_w[TIME_BITS-1:0];
      low_q  <= acc_q[QUO_BITS-1:0];
      dcnt_q <= DCW'(QUO_BITS);
    end
    if (cmd_in_i.div) begin
      rem_q  <= trial_ge ? trial_sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      quo_q  <= {quo_q[QUO_BITS-2:0], trial_ge};
      low_q  <= low_q << 1;
      dcnt_q <= dcnt_q - DCW'(1);
    end
    if (cmd_in_i.fin_load) begin
      count_q  <= enable_q ? count_ext[WORD_BITS-1:0] : '0;
      rate_q   <= rate_w;
      status_q <= status_w;
    end
  end

  assign count_value_o = count_q;
  assign rate_value_o  = rate_q;
  assign status_o      = status_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_in_i.div |-> rem_q < elapsed_q)
    else $error("partial remainder not below divisor");

  a_count_holds_between_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_in_i.load |=> $stable(pulse_count_q))
    else $error("count changed without an item");

  a_disabled_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_in_i.fin_load && !enable_q) |=> status_q == STAT_DISABLED && count_q == '0)
    else $error("disabled result not reported");

endmodule

`default_nettype wire

// ===== design/quadrature_pulse_counter_rate_core.sv =====
// Quadrature pulse counter with rate measurement.
// Input stream (s_axis_*): tuser carries the command (edge, preset, rate per
// second, rate per minute); tdata carries the pin levels, preset value and
// microsecond timestamp. Each transfer yields exactly one result transfer on
// m_axis_* carrying the count, the rate and a status code.
// Configuration (cfg_*): index 0 enables counting, index 1 selects quadrature
// direction; cfg_ready_o is always high. Write only while no item is in flight.
// An edge or preset item goes through the finish state, where its result is
// loaded into the output register once that register is free; so do rate
// items that are disabled or see zero elapsed time. Any other rate item runs
// multiply and accumulate steps, a check, the divider and the finish state:
// a 32-by-26 multiplier builds the scaled count one chunk per multiply and
// accumulate pair, then a restoring divider resolves one quotient bit per
// cycle; the divider is skipped if the check already finds saturation.
// Throughput: one item at a time; the next input is taken only after the
// previous item has left the finish state. One finished result may wait in
// the output register while the next item is taken and processed. If the
// receiver stalls, the block holds that next result and stops taking input.
// Reset clears the count, the last rate sample and both configuration bits.
`default_nettype none

module quadrature_pulse_counter_rate_core import qpcr_pkg::*; #(
  parameter int COUNT_BITS = 32,
  parameter int TIME_BITS  = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration write channel
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic                      cfg_data_i,
  // input stream
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [71:0]               s_axis_tdata,  // level_a, level_b, preset_value, now_us
  input  wire logic [1:0]                s_axis_tuser,  // cmd
  // result stream
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [71:0]                    m_axis_tdata   // count_value, rate_value, status
);

  qpcr_cmd_t             cmd;
  qpcr_sts_t             sts;
  logic [WORD_BITS-1:0]  count_value;
  logic [WORD_BITS-1:0]  rate_value;
  logic [1:0]            status;

  assign cfg_ready_o = 1'b1;

  qpcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qpcr_dp #(
    .COUNT_BITS (COUNT_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (s_axis_tuser),
    .level_a_i      (s_axis_tdata[0]),
    .level_b_i      (s_axis_tdata[1]),
    .preset_value_i (s_axis_tdata[33:2]),
    .now_us_i       (s_axis_tdata[65:34]),
    .count_value_o  (count_value),
    .rate_value_o   (rate_value),
    .status_o       (status),
    .cmd_in_i       (cmd),
    .sts_o          (sts)
  );

  // Pack the result, zero fill to whole bytes
  assign m_axis_tdata = {6'b0, status, rate_value, count_value};

endmodule

`default_nettype wire

// ===== sim/qpcr_scoreboard.sv =====
`default_nettype none

module qpcr_scoreboard import qpcr_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  input  wire logic                      cfg_ready_i,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic                      cfg_data_i,
  input  wire logic                      s_tvalid_i,
  input  wire logic                      s_tready_i,
  input  wire logic [71:0]               s_tdata_i,  // level_a, level_b, preset_value, now_us
  input  wire logic [1:0]                s_tuser_i,  // cmd
  input  wire logic                      m_tvalid_i,
  input  wire logic                      m_tready_i,
  input  wire logic [71:0]               m_tdata_i,  // count_value, rate_value, status
  output int                             pending_o,
  output int                             fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0]  count;
    logic [31:0]  rate;
    qpcr_status_e status;
  } reading_t;

  // Shadow of the configuration bits and the counter state
  logic        cnt_enable;
  logic        quad_dir;
  logic [31:0] tally;
  logic [31:0] mark_time;
  logic [31:0] mark_tally;

  reading_t expected_readings[$];
  int       fails;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fails++;
  endtask

  // Apply one input item to the shadow state and return the reading it produces
  function automatic reading_t predict_reading(input qpcr_op_e op, input logic lvl_a,
                                               input logic lvl_b, input logic [31:0] preset,
                                               input logic [31:0] now);
    reading_t    rd;
    logic [31:0] elapsed;
    logic [31:0] delta;
    logic [31:0] mag;
    logic [63:0] quo;
    logic        neg;
    rd.count  = '0;
    rd.rate   = '0;
    rd.status = STAT_OK;
    if (op == OP_PRESET) begin
      tally = preset;
    end else if (cnt_enable && op == OP_EDGE) begin
      // quadrature: levels differ means forward
      if (!quad_dir || (lvl_a ^ lvl_b)) tally = tally + 32'd1;
      else tally = tally - 32'd1;
    end else if (cnt_enable) begin
      elapsed = now - mark_time;
      delta   = tally - mark_tally;
      neg     = delta[31];
      mag     = neg ? -delta : delta;
      if (elapsed == '0) begin
        rd.status = STAT_ZERO_TIME;
      end else begin
        quo = (64'(mag) * 64'(op == OP_RATE_MIN ? SCALE_PER_MIN : SCALE_PER_SEC))
              / 64'(elapsed);
        if (neg) begin
          if (quo > 64'h8000_0000) begin
            quo       = 64'h8000_0000;
            rd.status = STAT_SATURATED;
          end
          rd.rate = -quo[31:0];
        end else begin
          if (quo > 64'h7FFF_FFFF) begin
            quo       = 64'h7FFF_FFFF;
            rd.status = STAT_SATURATED;
          end
          rd.rate = quo[31:0];
        end
      end
      // record the sample for the next rate query
      mark_time  = now;
      mark_tally = tally;
    end
    if (!cnt_enable) rd.status = STAT_DISABLED;
    else rd.count = tally;
    return rd;
  endfunction

  // Compare one result transfer against the oldest expectation
  task automatic check_reading(input logic [71:0] word);
    reading_t want;
    if (expected_readings.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing outstanding", word));
      return;
    end
    want = expected_readings.pop_front();
    if (word[31:0] !== want.count)
      report_mismatch($sformatf("count got %h want %h", word[31:0], want.count));
    if (word[63:32] !== want.rate)
      report_mismatch($sformatf("rate got %h want %h", word[63:32], want.rate));
    if (word[65:64] !== want.status)
      report_mismatch($sformatf("status got %h want %s", word[65:64], want.status.name()));
    if (word[71:66] !== '0)
      report_mismatch($sformatf("padding got %h", word[71:66]));
  endtask

  // Watch all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_enable   = 1'b0;
      quad_dir     = 1'b0;
      tally        = '0;
      mark_time    = '0;
      mark_tally   = '0;
      fails        = 0;
      expected_readings.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ENABLE: cnt_enable = cfg_data_i;
          REG_QUAD:   quad_dir   = cfg_data_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) check_reading(m_tdata_i);
      if (s_tvalid_i && s_tready_i)
        expected_readings.push_back(predict_reading(qpcr_op_e'(s_tuser_i), s_tdata_i[0],
                                                    s_tdata_i[1], s_tdata_i[33:2],
                                                    s_tdata_i[65:34]));
      pending_o    <= expected_readings.size();
      fail_count_o <= fails;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_quadrature_pulse_counter_rate_core.sv =====
`default_nettype none

module tb_quadrature_pulse_counter_rate_core import qpcr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 8'hFF;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 105;
  localparam logic PH_EN   [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam logic PH_QUAD [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
  // forward quadrature sequence as {level_b, level_a}
  localparam logic [1:0] GRAY [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

  logic                      clk_i     = 1'b0;
  logic                      rst_ni    = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic                      cfg_data  = 1'b0;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [71:0]               s_tdata   = '0;
  logic [1:0]                s_tuser   = '0;
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [71:0]               m_tdata;
  int                        pending;
  int                        fail_count;

  logic        src_idle_en = 1'b1;
  logic        stall_en    = 1'b1;
  logic [31:0] now_clock   = '0;
  int          quad_phase  = 0;

  always #5 clk_i = ~clk_i;

  quadrature_pulse_counter_rate_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  qpcr_scoreboard u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Register write; waits with valid low before returning
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one item, with an optional idle burst first; returns on the transfer edge
  task automatic send_item(input qpcr_op_e op, input logic lvl_a, input logic lvl_b,
                           input logic [31:0] preset, input logic [31:0] now);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, now, preset, lvl_b, lvl_a};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Drop valid and hold until every outstanding result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mostly realistic pulse trains and advancing timestamps, with some noise
  task automatic random_item();
    int          pick;
    int          step;
    logic [1:0]  lv;
    logic [31:0] preset;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      if ($urandom_range(0, 9) == 0) begin
        lv = 2'($urandom);
      end else begin
        // mostly one direction, sometimes reversing
        quad_phase = ($urandom_range(0, 4) == 0) ? quad_phase + 3 : quad_phase + 1;
        quad_phase = quad_phase % 4;
        lv = GRAY[quad_phase];
      end
      send_item(OP_EDGE, lv[0], lv[1], $urandom, $urandom);
    end else if (pick < 72) begin
      case ($urandom_range(0, 5))
        0, 1: preset = $urandom;
        2:    preset = 32'($urandom_range(0, 2000));
        3:    preset = -32'($urandom_range(1, 2000));
        4:    preset = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: preset = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      endcase
      send_item(OP_PRESET, 1'($urandom), 1'($urandom), preset, $urandom);
    end else begin
      step = $urandom_range(0, 9);
      case (step)
        0:       ;
        1, 2, 3: now_clock = now_clock + $urandom_range(1, 20);
        8:       now_clock = now_clock + $urandom;
        9:       now_clock = $urandom;
        default: now_clock = now_clock + $urandom_range(1000, 2000000);
      endcase
      send_item(pick < 86 ? OP_RATE_SEC : OP_RATE_MIN, 1'($urandom), 1'($urandom),
                $urandom, now_clock);
    end
  endtask

  // Receiver: random stall bursts while enabled
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled: ignored edge, preset still loads, rate changes nothing
    send_item(OP_EDGE, 1'b0, 1'b0, '0, '0);
    send_item(OP_PRESET, 1'b1, 1'b1, 32'd5, 32'hFFFF_FFFF);
    send_item(OP_RATE_SEC, 1'b0, 1'b0, '0, 32'd100);
    drain();
    write_reg(REG_ENABLE, 1'b1);
    write_reg(REG_UNMAPPED, 1'b1);

    // zero elapsed time, plain counting, both rate scales
    send_item(OP_RATE_SEC, 1'b0, 1'b0, '0, 32'd0);
    send_item(OP_EDGE, 1'b1, 1'b1, 32'hFFFF_FFFF, '0);
    send_item(OP_EDGE, 1'b0, 1'b0, '0, '0);
    send_item(OP_EDGE, 1'b1, 1'b0, '0, '0);
    send_item(OP_RATE_SEC, 1'b0, 1'b0, '0, 32'd1000);
    send_item(OP_RATE_MIN, 1'b0, 1'b0, '0, 32'd1000);
    // count wrap past the signed maximum, positive saturation
    send_item(OP_PRESET, 1'b0, 1'b0, 32'h7FFF_FFFF, '0);
    send_item(OP_EDGE, 1'b0, 1'b0, '0, '0);
    send_item(OP_RATE_SEC, 1'b0, 1'b0, '0, 32'd1001);
    // timestamp wrap and negative saturation
    send_item(OP_PRESET, 1'b0, 1'b0, 32'h0000_0000, '0);
    send_item(OP_RATE_MIN, 1'b0, 1'b0, '0, 32'hFFFF_FFF0);
    send_item(OP_PRESET, 1'b0, 1'b0, 32'h8000_0000, '0);
    send_item(OP_RATE_MIN, 1'b0, 1'b0, '0, 32'h0000_0010);
    drain();
    write_reg(REG_QUAD, 1'b1);

    // quadrature direction for all level pairs, then a small negative rate
    send_item(OP_EDGE, 1'b0, 1'b0, '0, '0);
    send_item(OP_EDGE, 1'b1, 1'b0, '0, '0);
    send_item(OP_EDGE, 1'b0, 1'b1, '0, '0);
    send_item(OP_EDGE, 1'b1, 1'b1, '0, '0);
    send_item(OP_EDGE, 1'b0, 1'b0, '0, '0);
    send_item(OP_RATE_SEC, 1'b0, 1'b0, '0, 32'h0000_0013);
    send_item(OP_PRESET, 1'b0, 1'b0, 32'hFFFF_FFFF, '0);
    send_item(OP_EDGE, 1'b1, 1'b0, '0, '0);
    now_clock = 32'h0000_0013;

    // random phases over the configuration space; last phase runs without gaps
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(REG_ENABLE, PH_EN[p]);
      write_reg(REG_QUAD, PH_QUAD[p]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        src_idle_en = (p < PHASES - 1) && !(k >= 40 && k < 60);
        stall_en    = (p < PHASES - 1) && !(k >= 50 && k < 70);
        random_item();
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
